>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers shared by the RTL, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)

`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

>>> rtl/core/spimrs_pkg.sv
// ----------------------------------------------------------------------------
// SPI master register sequencer package
// Register map, reset values, phase encoding and helpers.
// ----------------------------------------------------------------------------
package spimrs_pkg;

    localparam int BUFFER_WORDS_DEF = 16;

    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_RX    = 2'd2;

    localparam logic [11:0] REG_COMMAND = 12'h000;
    localparam logic [11:0] REG_ADDRESS = 12'h004;
    localparam logic [11:0] REG_CONTROL = 12'h008;
    localparam logic [11:0] REG_CLOCK   = 12'h00c;
    localparam logic [11:0] REG_USER    = 12'h010;
    localparam logic [11:0] REG_USER1   = 12'h014;
    localparam logic [11:0] REG_USER2   = 12'h018;
    localparam logic [11:0] REG_LENGTH  = 12'h01c;
    localparam logic [11:0] REG_MISC    = 12'h020;
    localparam logic [11:0] BUF_BASE    = 12'h098;

    localparam logic [31:0] CLOCK_RST = 32'h8000_3043;
    localparam logic [31:0] USER_RST  = 32'h8000_0000;
    localparam logic [31:0] USER1_RST = (32'd23 << 27) | 32'd7;
    localparam logic [31:0] USER2_RST = 32'd7 << 28;
    localparam logic [31:0] MISC_RST  = 32'h0000_003e;

    localparam int BIT_UPDATE  = 23;
    localparam int BIT_USR     = 24;
    localparam int BIT_MOSI    = 27;
    localparam int BIT_MISO    = 28;
    localparam int BIT_DUMMY   = 29;
    localparam int BIT_ADDR    = 30;
    localparam int BIT_CMD     = 31;
    localparam int BIT_KEEP_CS = 30;

    typedef enum logic [4:0] {
        PH_IDLE  = 5'b00001,
        PH_CMD   = 5'b00010,
        PH_ADDR  = 5'b00100,
        PH_DUMMY = 5'b01000,
        PH_DATA  = 5'b10000
    } phase_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } seq_state_t;

    // Lowest enabled phase among those allowed; bit 0 command up to bit 3 data.
    function automatic phase_t pick_phase(input logic [3:0] cand);
        phase_t p;
        p = PH_IDLE;
        priority if (cand[0]) p = PH_CMD;
        else if (cand[1]) p = PH_ADDR;
        else if (cand[2]) p = PH_DUMMY;
        else if (cand[3]) p = PH_DATA;
        else p = PH_IDLE;
        return p;
    endfunction

endpackage

>>> rtl/core/spi_master_register_sequencer_unit.sv
// Flow: an accepted item executes from registered inputs and its result is
// registered. No new item is taken until the last one has executed and the
// result register is free; the buffer read precedes each read-modify-write.
// Reset: state and mapped registers go to documented values at once; the buffer
// reads as zero through per-word valid bits, so no clearing pass is needed.
// ----------------------------------------------------------------------------
// SPI master register sequencer
// Register-mapped SPI master sending command, address, dummy and data bytes.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module spi_master_register_sequencer_unit #(
    parameter int BUFFER_WORDS = spimrs_pkg::BUFFER_WORDS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // reg_address[11:0], write_data[43:12], rx_byte[51:44]
    input  logic [55:0] s_axis_tdata,
    // operation[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // read_data[31:0], tx_valid[32], tx_byte[40:33], chip_select_active[41],
    // data_not_command[42], busy_res[43]
    output logic [47:0] m_axis_tdata,
    // transaction_done
    output logic        m_axis_tlast
);
    import spimrs_pkg::*;

    localparam int IDX_W    = (BUFFER_WORDS > 1) ? $clog2(BUFFER_WORDS) : 1;
    localparam int DATA_MAX = 4 * BUFFER_WORDS;
    localparam int BI_W     = $clog2(((DATA_MAX > 32) ? DATA_MAX : 32) + 1);

    seq_state_t state_reg, state_next;
    phase_t     phase_reg, phase_next;
    logic [BI_W-1:0] bi_reg, bi_next;
    logic cs_reg, cs_next, dc_reg, dc_next;

    logic [31:0] command_reg, command_next, address_reg, address_next;
    logic [31:0] control_reg, control_next, clock_reg, clock_next;
    logic [31:0] user_reg, user_next, user1_reg, user1_next;
    logic [31:0] user2_reg, user2_next, length_reg, length_next;
    logic [31:0] misc_reg, misc_next;
    logic [BUFFER_WORDS-1:0] valid_reg, valid_next;

    logic [1:0]  in_op_reg;
    logic [11:0] in_addr_reg;
    logic [31:0] in_wdata_reg;
    logic [7:0]  in_rx_reg;

    logic [31:0] mem [BUFFER_WORDS];
    logic [31:0] rda_reg, rdb_reg;
    logic [IDX_W-1:0] ra_a_reg, ra_b_reg;
    logic rda_ok_reg, rdb_ok_reg;

    logic out_valid_reg, out_valid_next;
    logic [31:0] out_rd_reg, out_rd_next;
    logic out_txv_reg, out_txv_next;
    logic [7:0] out_txb_reg, out_txb_next;
    logic out_cs_reg, out_cs_next, out_dc_reg, out_dc_next;
    logic out_busy_reg, out_busy_next, out_done_reg, out_done_next;

    logic s_fire;
    logic [IDX_W-1:0] ra_a, ra_b;
    logic [11:0] in_off;
    logic [BI_W-1:0] bi_inc, bi_inc_sh, bi_sh;
    logic mem_we;
    logic [IDX_W-1:0] mem_wa;
    logic [31:0] mem_wd;

    logic [BI_W-1:0] len_cmd, len_addr, len_dummy, len_data, len_cur;
    logic [4:0]  sum_cmd;
    logic [5:0]  sum_addr;
    logic [8:0]  sum_dummy;
    logic [18:0] sum_data;
    logic [3:0]  en_vec;

    assign s_fire = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE) && (!out_valid_reg || m_axis_tready);

    // Read addresses chosen at acceptance.
    always_comb
    begin
        in_off    = s_axis_tdata[11:0] - BUF_BASE;
        bi_sh     = bi_reg >> 2;
        bi_inc    = bi_reg + BI_W'(1);
        bi_inc_sh = bi_inc >> 2;
        if (s_axis_tuser == OP_READ)
        begin
            ra_a = in_off[IDX_W+1:2];
        end
        else
        begin
            ra_a = bi_sh[IDX_W-1:0];
        end
        if (phase_reg == PH_DATA)
        begin
            ra_b = bi_inc_sh[IDX_W-1:0];
        end
        else
        begin
            ra_b = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (s_fire)
        begin
            rda_reg <= mem[ra_a];
            rdb_reg <= mem[ra_b];
        end
    end

    // Phase lengths in bytes.
    always_comb
    begin
        sum_cmd   = {1'b0, user2_reg[31:28]} + 5'd8;
        sum_addr  = {1'b0, user1_reg[31:27]} + 6'd8;
        sum_dummy = {1'b0, user1_reg[7:0]} + 9'd8;
        sum_data  = {1'b0, length_reg[17:0]} + 19'd8;
        len_cmd   = BI_W'(sum_cmd[4:3]);
        len_addr  = BI_W'(sum_addr[5:3]);
        len_dummy = BI_W'(sum_dummy[8:3]);
        if (sum_data[18:3] > 16'(DATA_MAX))
        begin
            len_data = BI_W'(DATA_MAX);
        end
        else
        begin
            len_data = BI_W'(sum_data[18:3]);
        end
        en_vec = {user_reg[BIT_MOSI] | user_reg[BIT_MISO], user_reg[BIT_DUMMY],
                  user_reg[BIT_ADDR], user_reg[BIT_CMD]};
        unique case (phase_reg)
            PH_CMD:   len_cur = len_cmd;
            PH_ADDR:  len_cur = len_addr;
            PH_DUMMY: len_cur = len_dummy;
            PH_DATA:  len_cur = len_data;
            default:  len_cur = '0;
        endcase
    end

    function automatic logic [7:0] tx_of(input phase_t p, input logic [BI_W-1:0] i,
                                        input logic [BI_W-1:0] n, input logic [31:0] word,
                                        input logic [15:0] cmd_val, input logic [31:0] adr,
                                        input logic mosi);
        logic [BI_W-1:0] k;
        logic [31:0] v;
        k = n - BI_W'(1) - i;
        v = '0;
        unique case (p)
            PH_CMD:   v = {16'd0, cmd_val} >> {k[1:0], 3'b000};
            PH_ADDR:  v = adr >> {k[1:0], 3'b000};
            PH_DATA:  v = mosi ? (word >> {i[1:0], 3'b000}) : 32'd0;
            default:  v = '0;
        endcase
        return v[7:0];
    endfunction

    always_comb
    begin
        logic buf_hit;
        logic [11:0] off;
        logic [31:0] word_a, word_mod, word_b, cmd_v;
        logic [3:0] cand;
        phase_t sel;
        logic [BI_W-1:0] sel_len;
        logic rx_wr;

        state_next   = state_reg;
        phase_next   = phase_reg;
        bi_next      = bi_reg;
        cs_next      = cs_reg;
        dc_next      = dc_reg;
        command_next = command_reg;
        address_next = address_reg;
        control_next = control_reg;
        clock_next   = clock_reg;
        user_next    = user_reg;
        user1_next   = user1_reg;
        user2_next   = user2_reg;
        length_next  = length_reg;
        misc_next    = misc_reg;
        valid_next   = valid_reg;
        mem_we       = 1'b0;
        mem_wa       = ra_a_reg;
        mem_wd       = '0;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_rd_next   = out_rd_reg;
        out_txv_next  = out_txv_reg;
        out_txb_next  = out_txb_reg;
        out_cs_next   = out_cs_reg;
        out_dc_next   = out_dc_reg;
        out_busy_next = out_busy_reg;
        out_done_next = out_done_reg;

        off      = in_addr_reg - BUF_BASE;
        buf_hit  = (in_addr_reg >= BUF_BASE) && (in_addr_reg[1:0] == 2'b00)
                   && (off[11:2] < 10'(BUFFER_WORDS));
        word_a   = rda_ok_reg ? rda_reg : 32'd0;
        word_mod = word_a;
        word_mod[{bi_reg[1:0], 3'b000} +: 8] = in_rx_reg;
        rx_wr    = (in_op_reg == OP_RX) && (phase_reg == PH_DATA) && user_reg[BIT_MISO];
        if (rx_wr && (ra_a_reg == ra_b_reg))
        begin
            word_b = word_mod;
        end
        else
        begin
            word_b = rdb_ok_reg ? rdb_reg : 32'd0;
        end
        cmd_v   = in_wdata_reg;
        cand    = '0;
        sel     = PH_IDLE;
        sel_len = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_fire)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next     = ST_IDLE;
                out_valid_next = 1'b1;
                out_rd_next    = '0;
                out_txv_next   = 1'b0;
                out_txb_next   = '0;
                out_done_next  = 1'b0;
                if (in_op_reg == OP_READ)
                begin
                    unique case (in_addr_reg)
                        REG_COMMAND: out_rd_next = command_reg;
                        REG_ADDRESS: out_rd_next = address_reg;
                        REG_CONTROL: out_rd_next = control_reg;
                        REG_CLOCK:   out_rd_next = clock_reg;
                        REG_USER:    out_rd_next = user_reg;
                        REG_USER1:   out_rd_next = user1_reg;
                        REG_USER2:   out_rd_next = user2_reg;
                        REG_LENGTH:  out_rd_next = length_reg;
                        REG_MISC:    out_rd_next = misc_reg;
                        default:     out_rd_next = buf_hit ? word_a : 32'd0;
                    endcase
                end
                else if ((in_op_reg == OP_WRITE) && (phase_reg == PH_IDLE))
                begin
                    unique case (in_addr_reg)
                        REG_COMMAND:
                        begin
                            cmd_v[BIT_UPDATE] = 1'b0;
                            if (in_wdata_reg[BIT_USR])
                            begin
                                cs_next = 1'b1;
                                sel = pick_phase(en_vec);
                                unique case (sel)
                                    PH_CMD:   sel_len = len_cmd;
                                    PH_ADDR:  sel_len = len_addr;
                                    PH_DUMMY: sel_len = len_dummy;
                                    PH_DATA:  sel_len = len_data;
                                    default:  sel_len = '0;
                                endcase
                                if (sel != PH_IDLE)
                                begin
                                    phase_next   = sel;
                                    bi_next      = '0;
                                    dc_next      = (sel != PH_CMD);
                                    out_txv_next = 1'b1;
                                    out_txb_next = tx_of(sel, '0, sel_len, word_b,
                                                         user2_reg[15:0], address_reg,
                                                         user_reg[BIT_MOSI]);
                                end
                                else
                                begin
                                    cmd_v[BIT_USR] = 1'b0;
                                    cs_next        = misc_reg[BIT_KEEP_CS];
                                    out_done_next  = 1'b1;
                                end
                            end
                            command_next = cmd_v;
                        end
                        REG_ADDRESS: address_next = in_wdata_reg;
                        REG_CONTROL: control_next = in_wdata_reg;
                        REG_CLOCK:   clock_next   = in_wdata_reg;
                        REG_USER:    user_next    = in_wdata_reg;
                        REG_USER1:   user1_next   = in_wdata_reg;
                        REG_USER2:   user2_next   = in_wdata_reg;
                        REG_LENGTH:  length_next  = in_wdata_reg;
                        REG_MISC:    misc_next    = in_wdata_reg;
                        default:
                        begin
                            if (buf_hit)
                            begin
                                mem_we = 1'b1;
                                mem_wa = off[IDX_W+1:2];
                                mem_wd = in_wdata_reg;
                                valid_next[off[IDX_W+1:2]] = 1'b1;
                            end
                        end
                    endcase
                end
                else if ((in_op_reg == OP_RX) && (phase_reg != PH_IDLE))
                begin
                    if (rx_wr)
                    begin
                        mem_we = 1'b1;
                        mem_wa = ra_a_reg;
                        mem_wd = word_mod;
                        valid_next[ra_a_reg] = 1'b1;
                    end
                    if (bi_inc < len_cur)
                    begin
                        bi_next      = bi_inc;
                        out_txv_next = 1'b1;
                        out_txb_next = tx_of(phase_reg, bi_inc, len_cur, word_b,
                                             user2_reg[15:0], address_reg,
                                             user_reg[BIT_MOSI]);
                    end
                    else
                    begin
                        unique case (phase_reg)
                            PH_CMD:   cand = en_vec & 4'b1110;
                            PH_ADDR:  cand = en_vec & 4'b1100;
                            PH_DUMMY: cand = en_vec & 4'b1000;
                            default:  cand = 4'b0000;
                        endcase
                        sel = pick_phase(cand);
                        unique case (sel)
                            PH_ADDR:  sel_len = len_addr;
                            PH_DUMMY: sel_len = len_dummy;
                            PH_DATA:  sel_len = len_data;
                            default:  sel_len = '0;
                        endcase
                        if (sel != PH_IDLE)
                        begin
                            phase_next   = sel;
                            bi_next      = '0;
                            dc_next      = 1'b1;
                            out_txv_next = 1'b1;
                            out_txb_next = tx_of(sel, '0, sel_len, word_b,
                                                 user2_reg[15:0], address_reg,
                                                 user_reg[BIT_MOSI]);
                        end
                        else
                        begin
                            phase_next   = PH_IDLE;
                            bi_next      = '0;
                            cs_next      = cs_reg & misc_reg[BIT_KEEP_CS];
                            command_next = command_reg & ~(32'd1 << BIT_USR);
                            out_done_next = 1'b1;
                        end
                    end
                end
                out_cs_next   = cs_next;
                out_dc_next   = dc_next;
                out_busy_next = (phase_next != PH_IDLE);
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_IDLE;
            bi_reg        <= '0;
            cs_reg        <= 1'b0;
            dc_reg        <= 1'b1;
            command_reg   <= '0;
            address_reg   <= '0;
            control_reg   <= '0;
            clock_reg     <= CLOCK_RST;
            user_reg      <= USER_RST;
            user1_reg     <= USER1_RST;
            user2_reg     <= USER2_RST;
            length_reg    <= '0;
            misc_reg      <= MISC_RST;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
            rda_ok_reg    <= 1'b0;
            rdb_ok_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            bi_reg        <= bi_next;
            cs_reg        <= cs_next;
            dc_reg        <= dc_next;
            command_reg   <= command_next;
            address_reg   <= address_next;
            control_reg   <= control_next;
            clock_reg     <= clock_next;
            user_reg      <= user_next;
            user1_reg     <= user1_next;
            user2_reg     <= user2_next;
            length_reg    <= length_next;
            misc_reg      <= misc_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
            if (s_fire)
            begin
                rda_ok_reg <= valid_reg[ra_a];
                rdb_ok_reg <= valid_reg[ra_b];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            in_op_reg    <= s_axis_tuser;
            in_addr_reg  <= s_axis_tdata[11:0];
            in_wdata_reg <= s_axis_tdata[43:12];
            in_rx_reg    <= s_axis_tdata[51:44];
            ra_a_reg     <= ra_a;
            ra_b_reg     <= ra_b;
        end
        out_rd_reg   <= out_rd_next;
        out_txv_reg  <= out_txv_next;
        out_txb_reg  <= out_txb_next;
        out_cs_reg   <= out_cs_next;
        out_dc_reg   <= out_dc_next;
        out_busy_reg <= out_busy_next;
        out_done_reg <= out_done_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0000, out_busy_reg, out_dc_reg, out_cs_reg,
                            out_txb_reg, out_txv_reg, out_rd_reg};
    assign m_axis_tlast  = out_done_reg;

    `ASSERT_NEXT(a_accept_exec, clk, rst_n, s_fire, state_reg == ST_EXEC, "accept not followed by execute")
    `ASSERT_IMPLIES(a_exec_out_free, clk, rst_n, state_reg == ST_EXEC, !out_valid_reg, "result register busy in execute")
    `ASSERT_IMPLIES(a_busy_cs, clk, rst_n, phase_reg != PH_IDLE, cs_reg, "busy without chip select")
    `ASSERT_IMPLIES(a_done_idle, clk, rst_n, out_valid_reg && out_done_reg, !out_busy_reg && !out_txv_reg, "done result still busy")

endmodule

>>> tb/tb_spi_master_register_sequencer_unit.sv
// ----------------------------------------------------------------------------
// SPI master register sequencer testbench
// Sends bus reads, bus writes, returned bytes and spare operations into the input
// stream. A short table of directed items comes first, then constrained random
// items. Each output is checked field by field against a fixed or predicted reply.
// ----------------------------------------------------------------------------
module tb_spi_master_register_sequencer_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import spimrs_pkg::*;

    localparam int BUF_WORDS = BUFFER_WORDS_DEF;
    localparam logic [1:0] OP_SPARE = 2'd3;
    localparam int unsigned RANDOM_ITEMS = 450;
    localparam int unsigned HOLD_START = 600;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned STEADY_FROM = 1000;
    localparam int unsigned STEADY_TO = 1400;

    typedef struct packed {
        logic [31:0] rd;
        logic        txv;
        logic [7:0]  txb;
        logic        cs;
        logic        dc;
        logic        busy;
        logic        done;
    } spi_reply_t;

    typedef struct {
        logic [1:0]  op;
        logic [11:0] addr;
        logic [31:0] wdata;
        logic [7:0]  rx;
        bit          fixed;
        spi_reply_t  want;
    } bus_item_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic        m_axis_tlast;

    logic [31:0] m_command = '0;
    logic [31:0] m_address = '0;
    logic [31:0] m_control = '0;
    logic [31:0] m_clock = CLOCK_RST;
    logic [31:0] m_user = USER_RST;
    logic [31:0] m_user1 = USER1_RST;
    logic [31:0] m_user2 = USER2_RST;
    logic [31:0] m_length = '0;
    logic [31:0] m_misc = MISC_RST;
    logic [31:0] m_buffer [BUF_WORDS] = '{default: '0};
    phase_t      m_phase = PH_IDLE;
    int unsigned m_index = 0;
    logic        m_cs = 1'b0;
    logic        m_dc = 1'b1;

    spi_reply_t  replies_due [$];
    int          mismatches = 0;
    int unsigned ready_cycle = 0;
    int unsigned hold_left = 0;

    spi_master_register_sequencer_unit #(
        .BUFFER_WORDS(BUF_WORDS)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tlast(m_axis_tlast)
    );

    always #5 clk = ~clk;

    function automatic phase_t phase_after(phase_t p);
        case (p)
            PH_CMD:   return PH_ADDR;
            PH_ADDR:  return PH_DUMMY;
            PH_DUMMY: return PH_DATA;
            default:  return PH_IDLE;
        endcase
    endfunction

    function automatic int unsigned phase_bytes(phase_t p);
        int unsigned n;
        n = 0;
        case (p)
            PH_CMD:   if (m_user[BIT_CMD]) n = (int'(m_user2[31:28]) + 8) / 8;
            PH_ADDR:  if (m_user[BIT_ADDR]) n = (int'(m_user1[31:27]) + 8) / 8;
            PH_DUMMY: if (m_user[BIT_DUMMY]) n = (int'(m_user1[7:0]) + 8) / 8;
            PH_DATA:
                if (m_user[BIT_MOSI] || m_user[BIT_MISO])
                begin
                    n = (int'(m_length[17:0]) + 8) / 8;
                    if (n > 4 * BUF_WORDS) n = 4 * BUF_WORDS;
                end
            default:  n = 0;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] byte_on_wire();
        int unsigned n;
        int unsigned sh;
        logic [7:0]  b;
        n = phase_bytes(m_phase);
        b = 8'h00;
        if (m_index < n)
        begin
            sh = (n - 1 - m_index) * 8;
            case (m_phase)
                PH_CMD:  b = 8'(m_user2[15:0] >> sh);
                PH_ADDR: b = 8'(m_address >> sh);
                PH_DATA:
                    if (m_user[BIT_MOSI])
                        b = m_buffer[m_index / 4][(m_index % 4) * 8 +: 8];
                default: b = 8'h00;
            endcase
        end
        return b;
    endfunction

    function automatic bit enter_phase_from(phase_t p);
        phase_t q;
        q = p;
        while (q != PH_IDLE)
        begin
            if (phase_bytes(q) != 0)
            begin
                m_phase = q;
                m_index = 0;
                m_dc = (q != PH_CMD);
                return 1'b1;
            end
            q = phase_after(q);
        end
        return 1'b0;
    endfunction

    function automatic void close_transfer();
        m_phase = PH_IDLE;
        m_index = 0;
        if (!m_misc[BIT_KEEP_CS]) m_cs = 1'b0;
        m_command[BIT_USR] = 1'b0;
    endfunction

    function automatic int buffer_slot(logic [11:0] a);
        if (a >= BUF_BASE && a[1:0] == 2'b00 && (a - BUF_BASE) / 4 < BUF_WORDS)
            return int'((a - BUF_BASE) / 4);
        return -1;
    endfunction

    function automatic logic [31:0] register_value(logic [11:0] a);
        int w;
        w = buffer_slot(a);
        case (a)
            REG_COMMAND: return m_command;
            REG_ADDRESS: return m_address;
            REG_CONTROL: return m_control;
            REG_CLOCK:   return m_clock;
            REG_USER:    return m_user;
            REG_USER1:   return m_user1;
            REG_USER2:   return m_user2;
            REG_LENGTH:  return m_length;
            REG_MISC:    return m_misc;
            default:     return (w >= 0) ? m_buffer[w] : 32'h0;
        endcase
    endfunction

    function automatic spi_reply_t step_sequencer(bus_item_t it);
        spi_reply_t r;
        int         w;
        r = '0;
        if (it.op == OP_READ)
        begin
            r.rd = register_value(it.addr);
        end
        else if (it.op == OP_WRITE && m_phase == PH_IDLE)
        begin
            case (it.addr)
                REG_COMMAND:
                begin
                    m_command = it.wdata;
                    m_command[BIT_UPDATE] = 1'b0;
                    if (it.wdata[BIT_USR])
                    begin
                        m_cs = 1'b1;
                        if (enter_phase_from(PH_CMD))
                        begin
                            r.txv = 1'b1;
                            r.txb = byte_on_wire();
                        end
                        else
                        begin
                            close_transfer();
                            r.done = 1'b1;
                        end
                    end
                end
                REG_ADDRESS: m_address = it.wdata;
                REG_CONTROL: m_control = it.wdata;
                REG_CLOCK:   m_clock = it.wdata;
                REG_USER:    m_user = it.wdata;
                REG_USER1:   m_user1 = it.wdata;
                REG_USER2:   m_user2 = it.wdata;
                REG_LENGTH:  m_length = it.wdata;
                REG_MISC:    m_misc = it.wdata;
                default:
                begin
                    w = buffer_slot(it.addr);
                    if (w >= 0) m_buffer[w] = it.wdata;
                end
            endcase
        end
        else if (it.op == OP_RX && m_phase != PH_IDLE)
        begin
            if (m_phase == PH_DATA && m_user[BIT_MISO])
                m_buffer[m_index / 4][(m_index % 4) * 8 +: 8] = it.rx;
            m_index++;
            if (m_index < phase_bytes(m_phase) || enter_phase_from(phase_after(m_phase)))
            begin
                r.txv = 1'b1;
                r.txb = byte_on_wire();
            end
            else
            begin
                close_transfer();
                r.done = 1'b1;
            end
        end
        r.cs = m_cs;
        r.dc = m_dc;
        r.busy = (m_phase != PH_IDLE);
        return r;
    endfunction

    function automatic spi_reply_t idle_reply(logic [31:0] rd, logic done);
        spi_reply_t r;
        r = '0;
        r.rd = rd;
        r.dc = 1'b1;
        r.done = done;
        return r;
    endfunction

    function automatic bus_item_t row(logic [1:0] op, logic [11:0] addr, logic [31:0] wdata,
                                      logic [7:0] rx, bit fixed = 1'b0,
                                      spi_reply_t want = '0);
        bus_item_t it;
        it.op = op;
        it.addr = addr;
        it.wdata = wdata;
        it.rx = rx;
        it.fixed = fixed;
        it.want = want;
        return it;
    endfunction

    function automatic logic [11:0] register_at(int unsigned k);
        case (k)
            0:       return REG_COMMAND;
            1:       return REG_ADDRESS;
            2:       return REG_CONTROL;
            3:       return REG_CLOCK;
            4:       return REG_USER;
            5:       return REG_USER1;
            6:       return REG_USER2;
            7:       return REG_LENGTH;
            8:       return REG_MISC;
            default: return BUF_BASE + 12'(4 * $urandom_range(BUF_WORDS - 1));
        endcase
    endfunction

    function automatic bus_item_t random_item();
        bus_item_t   it;
        int unsigned r;
        it = row(OP_READ, 12'($urandom()), $urandom(), 8'($urandom()));
        r = $urandom_range(99);
        if (m_phase != PH_IDLE)
        begin
            if (r < 82)
            begin
                it.op = OP_RX;
            end
            else if (r < 90)
            begin
                if (r < 87) it.addr = register_at($urandom_range(10));
            end
            else if (r < 97)
            begin
                it.op = OP_WRITE;
                if (r < 94) it.addr = register_at($urandom_range(10));
            end
            else
            begin
                it.op = OP_SPARE;
            end
        end
        else if (r < 22)
        begin
            it.op = OP_WRITE;
            it.addr = REG_COMMAND;
            it.wdata[BIT_USR] = 1'b1;
        end
        else if (r < 55)
        begin
            it.op = OP_WRITE;
            it.addr = register_at($urandom_range(10));
            case (it.addr)
                REG_COMMAND: it.wdata[BIT_USR] = 1'b0;
                REG_USER1:
                    if ($urandom_range(9) != 0) it.wdata[7:0] = 8'($urandom_range(15));
                REG_LENGTH:
                    if ($urandom_range(9) != 0) it.wdata[17:0] = 18'($urandom_range(63));
                    else it.wdata[17:0] = '1;
                default: ;
            endcase
        end
        else if (r < 80)
        begin
            it.addr = register_at($urandom_range(10));
        end
        else
        begin
            it.op = 2'($urandom_range(3));
        end
        return it;
    endfunction

    function automatic void compare_field(string name, logic [31:0] due, logic [31:0] seen);
        if (due !== seen)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, due, seen);
            mismatches++;
        end
    endfunction

    task automatic offer_item(bus_item_t it, bit steady);
        spi_reply_t predicted;
        s_axis_tdata <= {4'b0000, it.rx, it.wdata, it.addr};
        s_axis_tuser <= it.op;
        s_axis_tvalid <= 1'b1;
        do @(posedge clk); while (!s_axis_tready);
        predicted = step_sequencer(it);
        replies_due.push_back(it.fixed ? it.want : predicted);
        if (!steady && $urandom_range(99) < 19)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    // The receiver holds off once for a long stretch so that the block backs up.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            ready_cycle++;
            if (ready_cycle == HOLD_START) hold_left = HOLD_CYCLES;
            if (hold_left != 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (ready_cycle >= STEADY_FROM && ready_cycle < STEADY_TO)
            begin
                m_axis_tready <= 1'b1;
            end
            else
            begin
                m_axis_tready <= ($urandom_range(99) >= 19);
            end
        end
    end

    always @(posedge clk)
    begin : watch_output
        spi_reply_t seen;
        spi_reply_t due;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            seen.rd = m_axis_tdata[31:0];
            seen.txv = m_axis_tdata[32];
            seen.txb = m_axis_tdata[40:33];
            seen.cs = m_axis_tdata[41];
            seen.dc = m_axis_tdata[42];
            seen.busy = m_axis_tdata[43];
            seen.done = m_axis_tlast;
            if (replies_due.size() == 0)
            begin
                $display("%0t: unexpected transaction, expected none, actual %h", $time,
                         m_axis_tdata);
                mismatches++;
            end
            else
            begin
                due = replies_due.pop_front();
                compare_field("read_data", due.rd, seen.rd);
                compare_field("tx_valid", due.txv, seen.txv);
                compare_field("tx_byte", due.txb, seen.txb);
                compare_field("chip_select_active", due.cs, seen.cs);
                compare_field("data_not_command", due.dc, seen.dc);
                compare_field("busy", due.busy, seen.busy);
                compare_field("transaction_done", due.done, seen.done);
            end
        end
    end

    initial
    begin : stimulus
        bus_item_t   directed [$];
        bus_item_t   it;
        int unsigned counted;
        bit          ignored;
        counted = 0;
        directed.push_back(row(OP_READ, REG_COMMAND, 32'h0, 8'h00, 1'b1,
                               idle_reply(32'h0, 1'b0)));
        directed.push_back(row(OP_READ, REG_CLOCK, 32'hffff_ffff, 8'hff, 1'b1,
                               idle_reply(CLOCK_RST, 1'b0)));
        directed.push_back(row(OP_READ, REG_USER, 32'h0, 8'h00, 1'b1,
                               idle_reply(USER_RST, 1'b0)));
        directed.push_back(row(OP_READ, 12'hfff, 32'h0, 8'h00, 1'b1,
                               idle_reply(32'h0, 1'b0)));
        directed.push_back(row(OP_READ, BUF_BASE + 12'd1, 32'h0, 8'h00, 1'b1,
                               idle_reply(32'h0, 1'b0)));
        directed.push_back(row(OP_READ, BUF_BASE + 12'(4 * (BUF_WORDS - 1)), 32'h0, 8'h00,
                               1'b1, idle_reply(32'h0, 1'b0)));
        directed.push_back(row(OP_SPARE, REG_CLOCK, 32'hffff_ffff, 8'hff, 1'b1,
                               idle_reply(32'h0, 1'b0)));
        directed.push_back(row(OP_RX, REG_COMMAND, 32'h0, 8'hff, 1'b1,
                               idle_reply(32'h0, 1'b0)));
        directed.push_back(row(OP_WRITE, REG_USER, 32'h0, 8'h00, 1'b1,
                               idle_reply(32'h0, 1'b0)));
        directed.push_back(row(OP_WRITE, REG_COMMAND, 32'hffff_ffff, 8'h00, 1'b1,
                               idle_reply(32'h0, 1'b1)));
        directed.push_back(row(OP_READ, REG_COMMAND, 32'h0, 8'h00));
        directed.push_back(row(OP_WRITE, REG_MISC, 32'hffff_ffff, 8'h00));
        directed.push_back(row(OP_WRITE, REG_USER, 32'hf800_0000, 8'h00));
        directed.push_back(row(OP_WRITE, REG_USER1, 32'h3800_0000, 8'h00));
        directed.push_back(row(OP_WRITE, REG_USER2, 32'hf000_abcd, 8'h00));
        directed.push_back(row(OP_WRITE, REG_LENGTH, 32'h0000_0007, 8'h00));
        directed.push_back(row(OP_WRITE, BUF_BASE, 32'h0000_00a5, 8'h00));
        directed.push_back(row(OP_WRITE, REG_ADDRESS, 32'h1234_5678, 8'h00));
        directed.push_back(row(OP_WRITE, REG_COMMAND, 32'h0100_0000, 8'h00));
        directed.push_back(row(OP_WRITE, REG_CONTROL, 32'hffff_ffff, 8'h00));
        directed.push_back(row(OP_RX, REG_COMMAND, 32'h0, 8'h00));
        directed.push_back(row(OP_RX, REG_COMMAND, 32'h0, 8'hff));
        directed.push_back(row(OP_RX, REG_COMMAND, 32'h0, 8'h5a));
        directed.push_back(row(OP_RX, REG_COMMAND, 32'h0, 8'h3c));
        directed.push_back(row(OP_RX, REG_COMMAND, 32'h0, 8'hc3));
        directed.push_back(row(OP_READ, BUF_BASE, 32'h0, 8'h00));

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed[i]) offer_item(directed[i], 1'b0);
        while (counted < RANDOM_ITEMS || m_phase != PH_IDLE)
        begin
            it = random_item();
            ignored = (it.op == OP_SPARE) || (it.op == OP_RX && m_phase == PH_IDLE)
                      || (it.op == OP_WRITE && m_phase != PH_IDLE);
            offer_item(it, counted >= 150 && counted < 250);
            if (!ignored) counted++;
        end
        s_axis_tvalid <= 1'b0;
        while (replies_due.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("tb_spi_master_register_sequencer_unit: done, clean");
        else
            $display("tb_spi_master_register_sequencer_unit: done, errors");
        $finish;
    end

    initial
    begin : watchdog
        #2_000_000;
        $display("tb_spi_master_register_sequencer_unit: done, errors");
        $finish;
    end

endmodule

>>> spi_master_register_sequencer_unit.f
+incdir+rtl/core
rtl/core/spimrs_pkg.sv
rtl/core/spi_master_register_sequencer_unit.sv
tb/tb_spi_master_register_sequencer_unit.sv
